[src/tmah_pkg.sv]
// shared types and constants of the thermal monitor
package tmah_pkg;

	localparam int TEMP_W = 12;
	localparam int ADC_W = 16;
	localparam int CODE_W = 12;

	// count saturation and conversion constants
	localparam logic [CODE_W-1:0] ADC_MAX = 12'd4095;
	localparam int PROD_W = 23;
	localparam logic [PROD_W-1:0] SPAN_TENTHS = 23'd1650;
	localparam logic [PROD_W-1:0] ROUND_HALF = 23'd2047;

	// floor(v / 4095) as (v * RECIP) >> RECIP_SHIFT, exact for v below 2**23
	localparam int RECIP_W = 24;
	localparam logic [RECIP_W-1:0] RECIP = 24'd8390657;
	localparam int RECIP_SHIFT = 35;
	localparam int FULL_W = PROD_W + RECIP_W;

	localparam logic signed [TEMP_W-1:0] TEMP_MIN = -12'sd400;

	// configuration port
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic signed [TEMP_W-1:0] THR_HIGH_RST = 12'sd850;
	localparam logic signed [TEMP_W-1:0] THR_LOW_RST = 12'sd800;

	typedef enum logic {
		REG_THR_HIGH = 1'b0,
		REG_THR_LOW  = 1'b1
	} reg_idx_t;

	typedef logic signed [TEMP_W-1:0] temp_t;

	// one slot of the sample window
	typedef struct packed {
		logic  valid;
		temp_t sample;
	} cell_t;

endpackage

[src/thermal_monitor_avg_hysteresis.sv]
// top level: count conversion, moving-average window and hysteresis alarm
//
// usage
//  - s_axis carries one raw converter count per item (adc_sample in tdata)
//  - m_axis returns one item per input item: the converted temperature, a flag
//    that the window was full, the window average and the alarm state
//  - thresholds are set through the apb port: high at 0x0, low at 0x4; the user
//    writes them only while no item is in flight, the block does not enforce it
//  - one item per cycle is sustained while m_tready stays high, the per-stage
//    ready chain letting new items in while finished items wait at the output
//    register
//  - the window is a chain of WINDOW_LEN cells that shifts once per item; the
//    running sum loop (subtract the oldest cell, add the newest) sets the rate
//  - the average is a reciprocal multiply over one stage, hysteresis and
//    output register in the next
//  - reset empties the window, clears the sum, sets the alarm to safe and
//    returns the thresholds to 850 and 800
//  - while m_tready is low the pipeline fills up and then drops s_tready;
//    nothing is lost or repeated
module thermal_monitor_avg_hysteresis
	import tmah_pkg::*;
#(
	parameter int WINDOW_LEN = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// apb configuration port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	// input stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [15:0]           s_tdata,  // [15:0] adc_sample
	// result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [11:0] temp_tenths, [12] avg_valid, [24:13] avg_tenths, [25] unsafe, rest zero
	output logic [31:0]           m_tdata
);

	localparam int CLOG_W = $clog2(WINDOW_LEN);
	// sum of WINDOW_LEN 12-bit signed samples
	localparam int SUM_W = TEMP_W + CLOG_W;
	// reciprocal of WINDOW_LEN, exact for magnitudes below 2**SUM_W
	localparam int DIV_S = SUM_W + CLOG_W;
	localparam longint DIV_M_L = ((64'sd1 <<< DIV_S) + WINDOW_LEN - 1) / WINDOW_LEN;
	localparam int DIV_M_W = $clog2(DIV_M_L + 1);
	localparam logic [DIV_M_W-1:0] DIV_M = DIV_M_W'(DIV_M_L);
	localparam int DPROD_W = SUM_W + DIV_M_W;

	// configuration registers
	temp_t thr_high_q;
	temp_t thr_low_q;
	logic  cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_high_q <= THR_HIGH_RST;
			thr_low_q <= THR_LOW_RST;
		end else if (cfg_wr) begin
			case (reg_idx_t'(paddr[2]))
				REG_THR_HIGH: thr_high_q <= pwdata[TEMP_W-1:0];
				REG_THR_LOW:  thr_low_q <= pwdata[TEMP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[2]))
			REG_THR_HIGH: prdata = APB_DATA_W'(thr_high_q);
			REG_THR_LOW:  prdata = APB_DATA_W'(thr_low_q);
			default:      prdata = '0;
		endcase
	end

	// conversion, stages 1 and 2
	logic  conv_valid;
	logic  conv_ready;
	temp_t conv_temp;

	tmah_conv u_conv (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.sample    (s_tdata[ADC_W-1:0]),
		.out_valid (conv_valid),
		.out_ready (conv_ready),
		.temp      (conv_temp)
	);

	// stage 3: window shift and running sum
	logic                    vld_s3;
	logic                    vld_s4;
	logic                    vld_s5;
	logic                    rdy_s3;
	logic                    rdy_s4;
	logic                    rdy_s5;
	logic                    load_s3;
	logic                    load_s4;
	logic                    load_s5;
	logic signed [SUM_W-1:0] sum_q;
	temp_t                   temp_s3;
	logic                    avgv_s3;
	cell_t                   chain [WINDOW_LEN+1];
	cell_t                   oldest;
	logic signed [SUM_W-1:0] drop;

	assign rdy_s5 = !vld_s5 || m_tready;
	assign rdy_s4 = !vld_s4 || rdy_s5;
	assign rdy_s3 = !vld_s3 || rdy_s4;
	assign conv_ready = rdy_s3;
	assign load_s3 = conv_valid && rdy_s3;
	assign load_s4 = vld_s3 && rdy_s4;
	assign load_s5 = vld_s4 && rdy_s5;

	// newest sample enters at the head, the oldest leaves at the tail
	assign chain[0] = '{valid: 1'b1, sample: conv_temp};

	for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
		tmah_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (load_s3),
			.d        (chain[i]),
			.q        (chain[i+1])
		);
	end

	assign oldest = chain[WINDOW_LEN];
	// an empty slot holds zero in the window's sum
	assign drop = oldest.valid ? SUM_W'(oldest.sample) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (load_s3) begin
				sum_q <= sum_q - drop + SUM_W'(conv_temp);
			end
			if (rdy_s3) begin
				vld_s3 <= conv_valid;
			end
			if (rdy_s4) begin
				vld_s4 <= vld_s3;
			end
			if (rdy_s5) begin
				vld_s5 <= vld_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s3) begin
			temp_s3 <= conv_temp;
			// the window was full when the leaving slot held a sample
			avgv_s3 <= oldest.valid;
		end
	end

	// stage 4: magnitude times reciprocal of the window length
	logic [SUM_W-1:0]   mag;
	logic [DPROD_W-1:0] prod_s4;
	logic               neg_s4;
	logic               avgv_s4;
	temp_t              temp_s4;

	assign mag = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);

	always_ff @(posedge clk) begin
		if (load_s4) begin
			prod_s4 <= DPROD_W'(mag) * DPROD_W'(DIV_M);
			neg_s4 <= sum_q[SUM_W-1];
			avgv_s4 <= avgv_s3;
			temp_s4 <= temp_s3;
		end
	end

	// stage 5: signed average, hysteresis and output register
	logic [TEMP_W-1:0] quot;
	temp_t             avg;
	logic              alarm_q;
	logic              alarm_nxt;
	temp_t             temp_s5;
	temp_t             avg_s5;
	logic              avgv_s5;

	assign quot = prod_s4[DIV_S +: TEMP_W];

	always_comb begin
		// truncation toward zero
		if (!avgv_s4) begin
			avg = '0;
		end else if (neg_s4) begin
			avg = -$signed(quot);
		end else begin
			avg = $signed(quot);
		end
		alarm_nxt = alarm_q;
		if (avgv_s4) begin
			if (!alarm_q && (avg >= thr_high_q)) begin
				alarm_nxt = 1'b1;
			end else if (alarm_q && (avg <= thr_low_q)) begin
				alarm_nxt = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alarm_q <= 1'b0;
		end else if (load_s5) begin
			alarm_q <= alarm_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s5) begin
			temp_s5 <= temp_s4;
			avg_s5 <= avg;
			avgv_s5 <= avgv_s4;
		end
	end

	assign m_tvalid = vld_s5;
	assign m_tdata = {6'd0, alarm_q, avg_s5, avgv_s5, temp_s5};

endmodule

[src/tmah_cell.sv]
// one slot of the sample window, shifting toward the oldest end
module tmah_cell
	import tmah_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  shift_en,
	input  cell_t d,
	output cell_t q
);

	logic  valid_q;
	temp_t sample_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift_en) begin
			valid_q <= d.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			sample_q <= d.sample;
		end
	end

	assign q = '{valid: valid_q, sample: sample_q};

endmodule

[src/tmah_conv.sv]
// two-stage converter from raw counts to tenths of a degree
module tmah_conv
	import tmah_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [ADC_W-1:0] sample,
	output logic             out_valid,
	input  logic             out_ready,
	output temp_t            temp
);

	logic              vld_s1;
	logic              vld_s2;
	logic [PROD_W-1:0] prod_s1;
	temp_t             temp_s2;

	logic              rdy_s1;
	logic              rdy_s2;
	logic [CODE_W-1:0] code;
	logic [FULL_W-1:0] full;
	logic [TEMP_W-1:0] quot;

	assign rdy_s2 = !vld_s2 || out_ready;
	assign rdy_s1 = !vld_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	// saturate, scale, add half the divisor for rounding
	assign code = (|sample[ADC_W-1:CODE_W]) ? ADC_MAX : sample[CODE_W-1:0];

	// quotient never exceeds 1650, so the result stays inside -400..1250
	assign full = FULL_W'(prod_s1) * FULL_W'(RECIP);
	assign quot = full[RECIP_SHIFT +: TEMP_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				vld_s1 <= in_valid;
			end
			if (rdy_s2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy_s1) begin
			prod_s1 <= PROD_W'(code) * SPAN_TENTHS + ROUND_HALF;
		end
		if (vld_s1 && rdy_s2) begin
			temp_s2 <= $signed(quot) + TEMP_MIN;
		end
	end

	assign out_valid = vld_s2;
	assign temp = temp_s2;

endmodule

[tb/tb_thermal_monitor_avg_hysteresis.sv]
// testbench of the thermal monitor: converted samples, window averages and alarm state
module tb_thermal_monitor_avg_hysteresis;
	timeunit 1ns;
	timeprecision 1ps;

	import tmah_pkg::*;

	localparam int WINDOW = 5;
	localparam int CLK_HALF = 4;
	localparam int RESET_CYCLES = 12;
	// a wide margin for the block to answer after an item goes in
	localparam int SETTLE_CYCLES = 16;
	localparam int IDLE_LIMIT = 2000;
	localparam int REPORT_MAX = 10;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 190;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [15:0]           s_tdata;  // [15:0] adc_sample
	logic                  m_tvalid;
	logic                  m_tready;
	// [11:0] temp_tenths, [12] avg_valid, [24:13] avg_tenths, [25] unsafe, rest zero
	logic [31:0]           m_tdata;

	// one predicted output item
	typedef struct {
		temp_t temp;
		logic  avg_ok;
		temp_t avg;
		logic  alarm;
	} reading_t;

	reading_t readings_due[$];

	// predictor copy of the block state
	temp_t window_q [WINDOW];
	int    window_sum;
	int    fill_n;
	int    slot_n;
	logic  alarm_q;
	temp_t thr_high;
	temp_t thr_low;

	// run bookkeeping
	logic steady;
	int   mismatch_count;
	int   items_sent;
	int   results_seen;
	int   settings_used;
	int   alarm_raised;
	int   alarm_cleared;
	int   idle_cycles;

	thermal_monitor_avg_hysteresis dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial clk = 1'b0;
	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// count saturation, then -400 + rounded scaling into tenths, then clamp
	function automatic temp_t count_to_tenths(input logic [15:0] code);
		int c;
		int t;
		c = (code > 16'd4095) ? 4095 : int'(code);
		t = -400 + (c * 1650 + 2047) / 4095;
		if (t < -400)
			t = -400;
		if (t > 1250)
			t = 1250;
		return temp_t'(t);
	endfunction

	// rough inverse, used only to aim the random samples at a temperature
	function automatic int tenths_to_count(input int t);
		int c;
		c = ((t + 400) * 4095 + 825) / 1650;
		if (c < 0)
			c = 0;
		if (c > 4095)
			c = 4095;
		return c;
	endfunction

	function automatic void reset_predictor();
		for (int i = 0; i < WINDOW; i++)
			window_q[i] = '0;
		window_sum = 0;
		fill_n = 0;
		slot_n = 0;
		alarm_q = 1'b0;
		thr_high = THR_HIGH_RST;
		thr_low = THR_LOW_RST;
	endfunction

	// advance the predictor by one accepted sample and queue what must come out
	function automatic void predict_reading(input logic [15:0] code);
		reading_t r;
		r.temp = count_to_tenths(code);
		r.avg_ok = 1'b0;
		r.avg = '0;
		if (fill_n < WINDOW) begin
			// window still filling: no average, alarm untouched
			window_q[slot_n] = r.temp;
			window_sum += int'(r.temp);
			fill_n++;
		end else begin
			window_sum -= int'(window_q[slot_n]);
			window_q[slot_n] = r.temp;
			window_sum += int'(r.temp);
			// int division truncates toward zero
			r.avg = temp_t'(window_sum / WINDOW);
			r.avg_ok = 1'b1;
		end
		slot_n = (slot_n + 1) % WINDOW;
		if (r.avg_ok) begin
			// thresholds compared as signed 12-bit values, even out of range
			if (!alarm_q && int'(r.avg) >= int'(thr_high)) begin
				alarm_q = 1'b1;
				alarm_raised++;
			end else if (alarm_q && int'(r.avg) <= int'(thr_low)) begin
				alarm_q = 1'b0;
				alarm_cleared++;
			end
		end
		r.alarm = alarm_q;
		readings_due.push_back(r);
	endfunction

	task automatic flag_error(input string what);
		if (mismatch_count < REPORT_MAX)
			$display("%0t: %s", $realtime, what);
		mismatch_count++;
	endtask

	// one item into the block; called and returns at a falling edge
	task automatic send_sample(input logic [15:0] code);
		// random gaps with tvalid low
		if (!steady) begin
			while ($urandom_range(99) < 7) begin
				s_tvalid <= 1'b0;
				@(negedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata <= code;
		do
			@(posedge clk);
		while (!s_tready);
		predict_reading(code);
		items_sent++;
		@(negedge clk);
	endtask

	// drop tvalid and wait until every queued item has come back
	task automatic wait_results_drained();
		s_tvalid <= 1'b0;
		while (readings_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// apb write: setup cycle, then access cycle until pready
	task automatic write_reg(input reg_idx_t idx, input temp_t val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {{(APB_DATA_W - TEMP_W){val[TEMP_W-1]}}, val};
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (idx == REG_THR_HIGH)
			thr_high = val;
		else
			thr_low = val;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_thresholds(input temp_t high, input temp_t low);
		wait_results_drained();
		write_reg(REG_THR_HIGH, high);
		// the bus goes idle between the two writes
		@(negedge clk);
		write_reg(REG_THR_LOW, low);
		settings_used++;
	endtask

	// a burst of samples around one temperature, or a burst of raw noise
	task automatic send_random_segment();
		int len;
		int target;
		int base;
		int code;
		if ($urandom_range(99) < 15) begin
			// full 16-bit noise, mostly saturating counts
			len = $urandom_range(5, 1);
			repeat (len) send_sample(16'($urandom));
		end else begin
			if ($urandom_range(2) == 0)
				target = int'($urandom_range(1650)) - 400;
			else begin
				// aim near one of the thresholds to make the alarm move
				target = ($urandom_range(1) != 0) ? int'(thr_high) : int'(thr_low);
				target = target + int'($urandom_range(160)) - 80;
			end
			if (target < -400)
				target = -400;
			if (target > 1250)
				target = 1250;
			base = tenths_to_count(target);
			len = $urandom_range(15, 3);
			repeat (len) begin
				code = base + int'($urandom_range(60)) - 30;
				if (code < 0)
					code = 0;
				if (code > 4095)
					code = 4095;
				send_sample(16'(code));
			end
		end
	endtask

	// window filling after reset, count extremes, saturation and rounding points
	task automatic test_conversion_corners();
		logic [15:0] codes [12];
		codes = '{16'd0, 16'd1, 16'd2, 16'd4094, 16'd4095, 16'd4096, 16'h8000,
			16'hffff, 16'd2047, 16'd2048, 16'd1240, 16'd3};
		foreach (codes[i])
			send_sample(codes[i]);
		wait_results_drained();
	endtask

	// default thresholds: rise past high, sit in the band, fall past low
	task automatic test_alarm_hysteresis();
		repeat (5) send_sample(16'd3400);
		repeat (3) send_sample(16'd3090);
		repeat (5) send_sample(16'd0);
		wait_results_drained();
	endtask

	// random samples under a series of threshold settings
	task automatic test_random_phases();
		int start;
		int h;
		int l;
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: set_thresholds(12'sd1250, -12'sd400);
				// low above high, both outside the temperature range
				1: set_thresholds(-12'sd2048, 12'sd2047);
				2: set_thresholds(12'sd2047, -12'sd2048);
				3: set_thresholds(12'sd300, 12'sd300);
				4: begin
					h = int'($urandom_range(1650)) - 400;
					l = h - int'($urandom_range(200));
					if (l < -400)
						l = -400;
					set_thresholds(temp_t'(h), temp_t'(l));
				end
				5: set_thresholds(temp_t'($urandom), temp_t'($urandom));
				// low above high, inside the range
				6: set_thresholds(-12'sd400, 12'sd1250);
				default: set_thresholds(THR_HIGH_RST, THR_LOW_RST);
			endcase
			// one phase runs with no idling on either side
			steady = (p == 3);
			start = items_sent;
			while (items_sent - start < PHASE_ITEMS) begin
				send_random_segment();
				// sender holds off mid-phase until the block has emptied
				if (p == 2 && items_sent - start >= PHASE_ITEMS / 2 &&
						items_sent - start < PHASE_ITEMS / 2 + 16)
					wait_results_drained();
			end
			steady = 1'b0;
		end
		wait_results_drained();
	endtask

	// receiver stalls at random, except in the steady stretch
	always @(negedge clk)
		m_tready <= steady || ($urandom_range(99) >= 7);

	// compare each output item with the oldest prediction
	always @(posedge clk) begin : check_results
		reading_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (readings_due.size() == 0)
				flag_error($sformatf("unexpected output item %h", m_tdata));
			else begin
				want = readings_due.pop_front();
				if (m_tdata[11:0] !== want.temp || m_tdata[12] !== want.avg_ok ||
						m_tdata[24:13] !== want.avg || m_tdata[25] !== want.alarm ||
						m_tdata[31:26] !== 6'd0)
					flag_error($sformatf({"mismatch: got temp %0d valid %b avg %0d unsafe %b",
						" pad %h, want temp %0d valid %b avg %0d unsafe %b"},
						$signed(m_tdata[11:0]), m_tdata[12], $signed(m_tdata[24:13]),
						m_tdata[25], m_tdata[31:26], want.temp, want.avg_ok, want.avg,
						want.alarm));
			end
		end
	end

	// watchdog: too many cycles with no item moving on either side
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
				$display("tb_thermal_monitor_avg_hysteresis: done, errors");
				$finish;
			end
		end
	end

	initial begin
		// every input known from time zero
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		steady = 1'b0;
		mismatch_count = 0;
		items_sent = 0;
		results_seen = 0;
		settings_used = 1;
		alarm_raised = 0;
		alarm_cleared = 0;
		idle_cycles = 0;
		reset_predictor();
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_conversion_corners();
		test_alarm_hysteresis();
		test_random_phases();

		// anything still queued here was never produced
		if (readings_due.size() != 0)
			flag_error($sformatf("%0d output items never arrived", readings_due.size()));
		$display("run covered %0d samples and %0d output items over %0d threshold settings",
			items_sent, results_seen, settings_used);
		$display("alarm raised %0d times and cleared %0d times, %0d mismatches",
			alarm_raised, alarm_cleared, mismatch_count);
		if (mismatch_count == 0)
			$display("tb_thermal_monitor_avg_hysteresis: done, clean");
		else
			$display("tb_thermal_monitor_avg_hysteresis: done, errors");
		$finish;
	end

endmodule
